FILE: rtl/pba_pkg.sv
// pba_pkg: shared types and constants for the page bump allocator.
// Request/response structs, status codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package pba_pkg;

	localparam int NUM_PAGES_DEF    = 256;
	localparam int PAGE_LOG2_DEF    = 12;
	localparam int HEADER_BYTES_DEF = 48;

	localparam int ADDR_W   = 20;
	localparam int NBYTES_W = 16;
	localparam int ALIGN_W  = 4;
	localparam int THR_W    = 13;
	localparam int OBJ_W    = 10;
	// bump arithmetic: top < 2^16, align <= 2^15, nbytes < 2^16
	localparam int BUMP_W   = 18;

	localparam logic [OBJ_W-1:0]   OBJ_MAX       = 10'd1023;
	localparam logic [ALIGN_W-1:0] MIN_LOG2_ALIGN = 4'd3;
	localparam logic [THR_W-1:0]   THR_RESET     = 13'd2048;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_PAGE      = 3'd1,
		ST_LARGE        = 3'd2,
		ST_NO_FIT       = 3'd3,
		ST_FREE_IGNORED = 3'd4,
		ST_BAD_FREE     = 3'd5
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [NBYTES_W-1:0] nbytes;
		logic [ALIGN_W-1:0]  align_exp;
		logic [ADDR_W-1:0]   free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		status_t           status;
		logic              page_released;
	} rsp_t;

	// write strobes and sequencing from the decision logic
	typedef struct packed {
		logic top_we;
		logic obj_we;
		logic link_we;
		logic go_retry;
		logic done;
	} ctl_t;

endpackage

FILE: rtl/page_bump_allocator_core.sv
// page_bump_allocator_core: top level of the page bump allocator.
// Instantiates pba_page_store and pba_decide; uses pba_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel: present req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. req.op selects allocate
//   or free; nbytes/align_exp matter for an allocate, free_address for a free.
//   Response channel: done pulses for exactly one cycle with rsp (address,
//   status, page_released). There is no backpressure; the receiver must take
//   the response in that cycle.
//   Config: cfg_we/cfg_wdata write large_threshold; write only while idle.
// Timing
//   On accept the request is captured and the page tables are read (current
//   page, or the freed page, plus the link of the stack head). In S_EXEC the
//   block decides, writes the tables back and registers the response.
//   busy stays high until the response is registered, so a new request is taken
//   only after the previous one is decided and written back. An allocate with no
//   current page whose size does not fit even an empty page must take a second
//   page and needs a second link read, done in S_RETRY.
// Reset
//   arst_n clears the page stack, fresh page count, current page and the
//   threshold (2048). Page tables are not cleared; a page is written when it
//   is first handed out, and entries are used only for such pages.

module page_bump_allocator_core #(
	parameter int NUM_PAGES    = pba_pkg::NUM_PAGES_DEF,
	parameter int PAGE_LOG2    = pba_pkg::PAGE_LOG2_DEF,
	parameter int HEADER_BYTES = pba_pkg::HEADER_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  pba_pkg::req_t             req,
	output logic                      done,
	output pba_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [pba_pkg::THR_W-1:0] cfg_wdata
);

	localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int FRESH_W = $clog2(NUM_PAGES + 1);
	localparam int APG_W   = pba_pkg::ADDR_W - PAGE_LOG2;
	localparam int IDX_W   = (APG_W > PAGE_W) ? APG_W : PAGE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RETRY
	} state_t;

	state_t                    state_q;
	pba_pkg::req_t             req_s1;
	logic [pba_pkg::THR_W-1:0] thr_q;
	logic [PAGE_W-1:0]         head_q;
	logic                      empty_q;
	logic [FRESH_W-1:0]        fresh_q;
	logic [PAGE_W-1:0]         cur_q;
	logic                      cur_valid_q;
	logic                      done_q;
	pba_pkg::rsp_t             rsp_q;

	logic                      accept, active;
	logic [IDX_W-1:0]          free_pg;
	logic [PAGE_W-1:0]         rd_addr, link_rd_addr;
	logic [PAGE_LOG2-1:0]      top_rdata;
	logic [pba_pkg::OBJ_W-1:0] obj_rdata;
	logic [PAGE_W-1:0]         link_rdata;

	logic [PAGE_W-1:0]         head_n, cur_n;
	logic                      empty_n, cur_valid_n;
	logic [FRESH_W-1:0]        fresh_n;
	logic [PAGE_W-1:0]         top_waddr, obj_waddr, link_waddr, link_wdata;
	logic [PAGE_LOG2-1:0]      top_wdata;
	logic [pba_pkg::OBJ_W-1:0] obj_wdata;
	pba_pkg::ctl_t             ctl;
	pba_pkg::rsp_t             rsp_n;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign active = state_q != S_IDLE;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// page index of a free; out-of-range pages are rejected later by count
	assign free_pg = IDX_W'(req.free_address[pba_pkg::ADDR_W-1:PAGE_LOG2]);
	assign rd_addr = (req.op == pba_pkg::OP_FREE) ? PAGE_W'(free_pg) : cur_q;

	// link port: stack head at accept; during EXEC the next head, for a
	// possible second pop in RETRY
	assign link_rd_addr = (state_q == S_EXEC) ? link_rdata : head_q;

	pba_page_store #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_LOG2 (PAGE_LOG2)
	) u_store (
		.clk          (clk),
		.rd_en        (accept),
		.rd_addr      (rd_addr),
		.top_rdata    (top_rdata),
		.obj_rdata    (obj_rdata),
		.link_rd_en   (accept || (state_q == S_EXEC)),
		.link_rd_addr (link_rd_addr),
		.link_rdata   (link_rdata),
		.top_we       (active && ctl.top_we),
		.top_waddr    (top_waddr),
		.top_wdata    (top_wdata),
		.obj_we       (active && ctl.obj_we),
		.obj_waddr    (obj_waddr),
		.obj_wdata    (obj_wdata),
		.link_we      (active && ctl.link_we),
		.link_waddr   (link_waddr),
		.link_wdata   (link_wdata)
	);

	pba_decide #(
		.NUM_PAGES    (NUM_PAGES),
		.PAGE_LOG2    (PAGE_LOG2),
		.HEADER_BYTES (HEADER_BYTES)
	) u_decide (
		.retry           (state_q == S_RETRY),
		.req             (req_s1),
		.large_threshold (thr_q),
		.top_rd          (top_rdata),
		.obj_rd          (obj_rdata),
		.link_rd         (link_rdata),
		.head            (head_q),
		.empty           (empty_q),
		.fresh           (fresh_q),
		.cur             (cur_q),
		.cur_valid       (cur_valid_q),
		.head_n          (head_n),
		.empty_n         (empty_n),
		.fresh_n         (fresh_n),
		.cur_n           (cur_n),
		.cur_valid_n     (cur_valid_n),
		.top_waddr       (top_waddr),
		.top_wdata       (top_wdata),
		.obj_waddr       (obj_waddr),
		.obj_wdata       (obj_wdata),
		.link_waddr      (link_waddr),
		.link_wdata      (link_wdata),
		.ctl             (ctl),
		.rsp             (rsp_n)
	);

	// request capture; payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= pba_pkg::THR_RESET;
			head_q      <= '0;
			empty_q     <= 1'b1;
			fresh_q     <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (active) begin
				head_q      <= head_n;
				empty_q     <= empty_n;
				fresh_q     <= fresh_n;
				cur_q       <= cur_n;
				cur_valid_q <= cur_valid_n;
				if (ctl.done) begin
					done_q <= 1'b1;
					rsp_q  <= rsp_n;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= ctl.go_retry ? S_RETRY : S_IDLE;
				end
				S_RETRY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/pba_page_store.sv
// pba_page_store: per-page tables (top offset, object count, stack link).
// Synchronous write, registered read. Uses pba_pkg.
`timescale 1ns / 1ps

module pba_page_store #(
	parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF,
	parameter int PAGE_LOG2 = pba_pkg::PAGE_LOG2_DEF,
	localparam int PAGE_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
	input  logic                      clk,
	// top/object read port
	input  logic                      rd_en,
	input  logic [PAGE_W-1:0]         rd_addr,
	output logic [PAGE_LOG2-1:0]      top_rdata,
	output logic [pba_pkg::OBJ_W-1:0] obj_rdata,
	// link read port
	input  logic                      link_rd_en,
	input  logic [PAGE_W-1:0]         link_rd_addr,
	output logic [PAGE_W-1:0]         link_rdata,
	// writes
	input  logic                      top_we,
	input  logic [PAGE_W-1:0]         top_waddr,
	input  logic [PAGE_LOG2-1:0]      top_wdata,
	input  logic                      obj_we,
	input  logic [PAGE_W-1:0]         obj_waddr,
	input  logic [pba_pkg::OBJ_W-1:0] obj_wdata,
	input  logic                      link_we,
	input  logic [PAGE_W-1:0]         link_waddr,
	input  logic [PAGE_W-1:0]         link_wdata
);

	logic [PAGE_LOG2-1:0]      top_mem  [NUM_PAGES];
	logic [pba_pkg::OBJ_W-1:0] obj_mem  [NUM_PAGES];
	logic [PAGE_W-1:0]         link_mem [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (top_we) begin
			top_mem[top_waddr] <= top_wdata;
		end
		if (rd_en) begin
			top_rdata <= top_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (obj_we) begin
			obj_mem[obj_waddr] <= obj_wdata;
		end
		if (rd_en) begin
			obj_rdata <= obj_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (link_rd_en) begin
			link_rdata <= link_mem[link_rd_addr];
		end
	end

endmodule

FILE: rtl/pba_decide.sv
// pba_decide: combinational decision logic for one allocate or free (and its retry).
// Bump/fit arithmetic, page obtain (stack pop or fresh), free bookkeeping.
// Uses pba_pkg.
`timescale 1ns / 1ps

module pba_decide #(
	parameter int NUM_PAGES    = pba_pkg::NUM_PAGES_DEF,
	parameter int PAGE_LOG2    = pba_pkg::PAGE_LOG2_DEF,
	parameter int HEADER_BYTES = pba_pkg::HEADER_BYTES_DEF,
	localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
	localparam int FRESH_W     = $clog2(NUM_PAGES + 1)
) (
	input  logic                      retry,
	input  pba_pkg::req_t             req,
	input  logic [pba_pkg::THR_W-1:0] large_threshold,
	input  logic [PAGE_LOG2-1:0]      top_rd,
	input  logic [pba_pkg::OBJ_W-1:0] obj_rd,
	input  logic [PAGE_W-1:0]         link_rd,
	input  logic [PAGE_W-1:0]         head,
	input  logic                      empty,
	input  logic [FRESH_W-1:0]        fresh,
	input  logic [PAGE_W-1:0]         cur,
	input  logic                      cur_valid,
	output logic [PAGE_W-1:0]         head_n,
	output logic                      empty_n,
	output logic [FRESH_W-1:0]        fresh_n,
	output logic [PAGE_W-1:0]         cur_n,
	output logic                      cur_valid_n,
	output logic [PAGE_W-1:0]         top_waddr,
	output logic [PAGE_LOG2-1:0]      top_wdata,
	output logic [PAGE_W-1:0]         obj_waddr,
	output logic [pba_pkg::OBJ_W-1:0] obj_wdata,
	output logic [PAGE_W-1:0]         link_waddr,
	output logic [PAGE_W-1:0]         link_wdata,
	output pba_pkg::ctl_t             ctl,
	output pba_pkg::rsp_t             rsp
);

	localparam int BW      = pba_pkg::BUMP_W;
	localparam int APG_W   = pba_pkg::ADDR_W - PAGE_LOG2;
	localparam int CMP_W   = (APG_W > FRESH_W) ? APG_W : FRESH_W;
	localparam int FULL_W  = PAGE_W + PAGE_LOG2;
	localparam logic [PAGE_LOG2-1:0] HDR = PAGE_LOG2'(HEADER_BYTES);

	logic [pba_pkg::ALIGN_W-1:0]  la;
	logic [pba_pkg::NBYTES_W-1:0] align;
	logic [BW-1:0]                amask;
	logic                         oversize;
	logic [BW-1:0]                cur_base, cur_end, hdr_base, hdr_end;
	logic                         cur_fit, hdr_fit;
	logic                         can_pop, can_fresh, got, bottom;
	logic [PAGE_W-1:0]            p_new;
	logic [PAGE_LOG2-1:0]         off;
	logic [CMP_W-1:0]             fa_pg, fresh_ext;
	logic [PAGE_W-1:0]            p_free;
	logic                         take, ok;
	logic [PAGE_W-1:0]            ok_page;
	logic [PAGE_LOG2-1:0]         ok_off;
	logic [FULL_W-1:0]            full_addr;

	assign la    = (req.align_exp < pba_pkg::MIN_LOG2_ALIGN) ? pba_pkg::MIN_LOG2_ALIGN
	                                                         : req.align_exp;
	assign align = pba_pkg::NBYTES_W'(1) << la;
	assign amask = BW'(align) - BW'(1);
	assign oversize = (req.nbytes >= pba_pkg::NBYTES_W'(large_threshold)) ||
	                  (align >= pba_pkg::NBYTES_W'(large_threshold));

	// align up, then add size; fit means end stays below the page size
	assign cur_base = (BW'(top_rd) + amask) & ~amask;
	assign cur_end  = cur_base + BW'(req.nbytes);
	assign cur_fit  = (cur_end >> PAGE_LOG2) == '0;
	assign hdr_base = (BW'(HDR) + amask) & ~amask;
	assign hdr_end  = hdr_base + BW'(req.nbytes);
	assign hdr_fit  = (hdr_end >> PAGE_LOG2) == '0;

	// page obtain: stack first, then a never-used page
	assign can_pop   = !empty;
	assign can_fresh = fresh < FRESH_W'(NUM_PAGES);
	assign got       = can_pop || can_fresh;
	assign bottom    = link_rd == head;
	assign p_new     = can_pop ? head : PAGE_W'(fresh);

	assign off       = req.free_address[PAGE_LOG2-1:0];
	assign fa_pg     = CMP_W'(req.free_address[pba_pkg::ADDR_W-1:PAGE_LOG2]);
	assign fresh_ext = CMP_W'(fresh);
	assign p_free    = PAGE_W'(fa_pg);

	assign full_addr = {ok_page, ok_off};

	always_comb begin
		head_n      = head;
		empty_n     = empty;
		fresh_n     = fresh;
		cur_n       = cur;
		cur_valid_n = cur_valid;
		top_waddr   = cur;
		top_wdata   = HDR;
		obj_waddr   = cur;
		obj_wdata   = '0;
		link_waddr  = p_new;
		link_wdata  = p_new;
		ctl         = '0;
		take        = 1'b0;
		ok          = 1'b0;
		ok_page     = cur;
		ok_off      = '0;
		rsp         = '0;
		rsp.status  = pba_pkg::ST_OK;

		if (retry) begin
			// second obtain after the first fresh/popped page was too small
			ctl.done = 1'b1;
			if (!got) begin
				rsp.status = pba_pkg::ST_NO_PAGE;
			end else begin
				take       = 1'b1;
				cur_n      = p_new;
				rsp.status = pba_pkg::ST_NO_FIT;
			end
		end else if (req.op == pba_pkg::OP_ALLOC) begin
			if (oversize) begin
				ctl.done   = 1'b1;
				rsp.status = pba_pkg::ST_LARGE;
			end else if (cur_valid && cur_fit) begin
				ctl.done = 1'b1;
				ok       = 1'b1;
				ok_page  = cur;
				ok_off   = cur_base[PAGE_LOG2-1:0];
				top_waddr  = cur;
				top_wdata  = cur_end[PAGE_LOG2-1:0];
				ctl.top_we = 1'b1;
				obj_waddr  = cur;
				obj_wdata  = (obj_rd == pba_pkg::OBJ_MAX) ? obj_rd
				                                          : obj_rd + pba_pkg::OBJ_W'(1);
				ctl.obj_we = 1'b1;
			end else if (!got) begin
				ctl.done   = 1'b1;
				rsp.status = pba_pkg::ST_NO_PAGE;
			end else begin
				take        = 1'b1;
				cur_n       = p_new;
				cur_valid_n = 1'b1;
				if (hdr_fit) begin
					ctl.done   = 1'b1;
					ok         = 1'b1;
					ok_page    = p_new;
					ok_off     = hdr_base[PAGE_LOG2-1:0];
					top_waddr  = p_new;
					top_wdata  = hdr_end[PAGE_LOG2-1:0];
					ctl.top_we = 1'b1;
					obj_waddr  = p_new;
					obj_wdata  = pba_pkg::OBJ_W'(1);
					ctl.obj_we = 1'b1;
				end else if (cur_valid) begin
					ctl.done   = 1'b1;
					rsp.status = pba_pkg::ST_NO_FIT;
				end else begin
					// no current page before: a second page is obtained in the retry pass
					ctl.go_retry = 1'b1;
				end
			end
		end else begin
			ctl.done = 1'b1;
			if (off == '0) begin
				rsp.status = pba_pkg::ST_FREE_IGNORED;
			end else if ((fa_pg >= fresh_ext) || (obj_rd == '0)) begin
				rsp.status = pba_pkg::ST_BAD_FREE;
			end else begin
				obj_waddr  = p_free;
				obj_wdata  = obj_rd - pba_pkg::OBJ_W'(1);
				ctl.obj_we = 1'b1;
				if (obj_rd == pba_pkg::OBJ_W'(1)) begin
					top_waddr         = p_free;
					top_wdata         = HDR;
					ctl.top_we        = 1'b1;
					rsp.page_released = 1'b1;
					if (!(cur_valid && (cur == p_free))) begin
						link_waddr  = p_free;
						link_wdata  = empty ? p_free : head;
						ctl.link_we = 1'b1;
						head_n      = p_free;
						empty_n     = 1'b0;
					end
				end
			end
		end

		// apply the page obtain chosen above
		if (take) begin
			if (can_pop) begin
				if (bottom) begin
					empty_n = 1'b1;
				end else begin
					head_n = link_rd;
				end
			end else begin
				fresh_n     = fresh + FRESH_W'(1);
				link_waddr  = p_new;
				link_wdata  = p_new;
				ctl.link_we = 1'b1;
				if (!ctl.top_we) begin
					top_waddr  = p_new;
					top_wdata  = HDR;
					ctl.top_we = 1'b1;
				end
				if (!ctl.obj_we) begin
					obj_waddr  = p_new;
					obj_wdata  = '0;
					ctl.obj_we = 1'b1;
				end
			end
		end

		if (ok) begin
			rsp.address = pba_pkg::ADDR_W'(full_addr);
		end
	end

endmodule
